// ----- hdl/ast_pkg.sv -----
// Shared types, constants and helper functions for the arc sector tessellator.
package ast_pkg;

    localparam int unsigned MIN_SEGS   = 3;
    localparam logic [4:0]  SEG_RESET  = 5'd20;
    localparam int unsigned ATAN_DEPTH = 24;
    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;

    // Command codes
    localparam logic CMD_FAN  = 1'b0;
    localparam logic CMD_RING = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [15:0]        inner_radius;
        logic [15:0]        outer_radius;
        logic [16:0]        angle_start;
        logic [16:0]        angle_end;
        logic [15:0]        depth;
        logic [31:0]        color_rgba;
    } in_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        vertex_depth;
        logic [31:0]        vertex_color;
        logic [5:0]         vertex_index;
        logic               has_triangle;
        logic [5:0]         tri_a;
        logic [5:0]         tri_b;
        logic [5:0]         tri_c;
        logic               last;
    } out_t;

    // One classified command handed from the front end to the back end
    typedef struct packed {
        in_t         data;
        logic [16:0] lo;
        logic [31:0] quot;
        logic [4:0]  rem;
        logic [4:0]  segs;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CENTER,
        B_START,
        B_CORDIC,
        B_MULX,
        B_MULY,
        B_EMIT
    } back_state_t;

    // CORDIC arctangent table, Q30 with a quarter turn at 2^30
    function automatic logic signed [33:0] atan_val(input logic [4:0] k);
        logic signed [33:0] v;
        case (k)
            5'd0:    v = 34'sh20000000;
            5'd1:    v = 34'sh12E4051E;
            5'd2:    v = 34'sh09FB385B;
            5'd3:    v = 34'sh051111D4;
            5'd4:    v = 34'sh028B0D43;
            5'd5:    v = 34'sh0145D7E1;
            5'd6:    v = 34'sh00A2F61E;
            5'd7:    v = 34'sh00517C55;
            5'd8:    v = 34'sh0028BE53;
            5'd9:    v = 34'sh00145F2F;
            5'd10:   v = 34'sh000A2F98;
            5'd11:   v = 34'sh000517CC;
            5'd12:   v = 34'sh00028BE6;
            5'd13:   v = 34'sh000145F3;
            5'd14:   v = 34'sh0000A2FA;
            5'd15:   v = 34'sh0000517D;
            5'd16:   v = 34'sh000028BE;
            5'd17:   v = 34'sh0000145F;
            5'd18:   v = 34'sh00000A30;
            5'd19:   v = 34'sh00000518;
            5'd20:   v = 34'sh0000028C;
            5'd21:   v = 34'sh00000146;
            5'd22:   v = 34'sh000000A3;
            5'd23:   v = 34'sh00000051;
            default: v = 34'sh0;
        endcase
        return v;
    endfunction

    // Round the Q30 product half up, add the center and saturate to 16 bits
    function automatic logic signed [15:0] place(input logic signed [50:0] prod,
                                                 input logic signed [15:0] center);
        logic signed [50:0] rnd;
        logic signed [21:0] v;
        rnd = prod + 51'sd536870912;
        v = {rnd[50], rnd[50:30]} + {{6{center[15]}}, center};
        if (v > 22'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -22'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

// ----- hdl/ast_front.sv -----
// Front end: accept a command, order the angles, divide the span by the step count.
module ast_front #(
    parameter int unsigned MAX_SEGMENTS = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [4:0]    seg_cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  ast_pkg::in_t  in_data,
    output logic          job_valid,
    input  logic          job_ready,
    output ast_pkg::job_t job_data
);
    import ast_pkg::*;

    front_state_t state_reg, state_next;
    job_t         job_reg, job_next;
    logic [32:0]  div_reg, div_next;
    logic [4:0]   rem_reg, rem_next;
    logic [5:0]   cnt_reg, cnt_next;

    logic [16:0]  lo_w, span_w;
    logic [4:0]   segs_w;
    logic [5:0]   trial;
    logic         ge;

    // Order the angles and clamp the step count
    always_comb begin
        if (in_data.angle_start < in_data.angle_end) begin
            lo_w   = in_data.angle_start;
            span_w = in_data.angle_end - in_data.angle_start;
        end else begin
            lo_w   = in_data.angle_end;
            span_w = in_data.angle_start - in_data.angle_end;
        end
        segs_w = seg_cfg;
        if (32'(seg_cfg) > MAX_SEGMENTS) begin
            segs_w = 5'(MAX_SEGMENTS);
        end
        if (32'(segs_w) < MIN_SEGS) begin
            segs_w = 5'(MIN_SEGS);
        end
    end

    // One quotient bit per cycle
    assign trial = {rem_reg, div_reg[32]};
    assign ge    = trial >= {1'b0, job_reg.segs};

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        job_valid  = 1'b0;
        case (state_reg)
            F_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    job_next.data = in_data;
                    job_next.lo   = lo_w;
                    job_next.segs = segs_w;
                    div_next      = {span_w, 16'h0};
                    rem_next      = 5'd0;
                    cnt_next      = 6'd0;
                    state_next    = F_DIV;
                end
            end
            F_DIV: begin
                rem_next = ge ? 5'(trial - {1'b0, job_reg.segs}) : trial[4:0];
                div_next = {div_reg[31:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd32) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                job_valid = 1'b1;
                if (job_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        job_data      = job_reg;
        job_data.quot = div_reg[31:0];
        job_data.rem  = rem_reg;
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        job_reg <= job_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

endmodule

// ----- hdl/ast_fifo.sv -----
// Two-entry job queue between the front end and the back end.
module ast_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ast_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ast_pkg::job_t pop_data
);
    import ast_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/ast_back.sv -----
// Back end: step angles, run the CORDIC, scale by radius and emit vertex beats.
module ast_back #(
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  ast_pkg::job_t job_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ast_pkg::out_t out_data
);
    import ast_pkg::*;

    back_state_t        state_reg, state_next;
    job_t               job_reg, job_next;
    logic [4:0]         step_reg, step_next;
    logic [31:0]        q_reg, q_next;
    logic [4:0]         r_reg, r_next;
    logic               side_reg, side_next;
    logic [4:0]         it_reg, it_next;
    logic [1:0]         quad_reg, quad_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [50:0] prod_reg, prod_next;
    logic signed [15:0] px_reg, px_next;
    out_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               ring, free;
    logic [31:0]        phase;
    logic signed [33:0] cos_w, sin_w;
    logic [15:0]        rad;
    logic [5:0]         rsum;
    logic               carry;
    logic [5:0]         ii;

    assign ring  = job_reg.data.command == CMD_RING;
    assign free  = !out_valid_reg || out_ready;
    assign phase = {job_reg.lo[15:0], 16'h0} + q_reg;
    assign rad   = (ring && !side_reg) ? job_reg.data.inner_radius
                                       : job_reg.data.outer_radius;
    assign rsum  = {1'b0, r_reg} + {1'b0, job_reg.rem};
    assign carry = rsum >= {1'b0, job_reg.segs};
    assign ii    = {1'b0, step_reg};

    // Apply the quadrant by swap and negate
    always_comb begin
        case (quad_reg)
            2'd0:    begin cos_w = x_reg;  sin_w = y_reg;  end
            2'd1:    begin cos_w = -y_reg; sin_w = x_reg;  end
            2'd2:    begin cos_w = -x_reg; sin_w = -y_reg; end
            default: begin cos_w = y_reg;  sin_w = -x_reg; end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        step_next      = step_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        side_next      = side_reg;
        it_next        = it_reg;
        quad_next      = quad_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        prod_next      = prod_reg;
        px_next        = px_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        job_ready      = 1'b0;
        case (state_reg)
            B_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    job_next  = job_data;
                    step_next = 5'd0;
                    q_next    = 32'd0;
                    r_next    = 5'd0;
                    side_next = 1'b0;
                    state_next = (job_data.data.command == CMD_RING) ? B_START : B_CENTER;
                end
            end
            B_CENTER: begin
                if (free) begin
                    out_next              = '0;
                    out_next.pos_x        = job_reg.data.center_x;
                    out_next.pos_y        = job_reg.data.center_y;
                    out_next.vertex_depth = job_reg.data.depth;
                    out_next.vertex_color = job_reg.data.color_rgba;
                    out_valid_next        = 1'b1;
                    state_next            = B_START;
                end
            end
            B_START: begin
                x_next     = INV_GAIN;
                y_next     = 34'sd0;
                z_next     = $signed({4'b0, phase[29:0]});
                quad_next  = phase[31:30];
                it_next    = 5'd0;
                state_next = B_CORDIC;
            end
            B_CORDIC: begin
                if (!z_reg[33]) begin
                    x_next = x_reg - (y_reg >>> it_reg);
                    y_next = y_reg + (x_reg >>> it_reg);
                    z_next = z_reg - atan_val(it_reg);
                end else begin
                    x_next = x_reg + (y_reg >>> it_reg);
                    y_next = y_reg - (x_reg >>> it_reg);
                    z_next = z_reg + atan_val(it_reg);
                end
                it_next = it_reg + 5'd1;
                if (32'(it_reg) == CORDIC_ITERATIONS - 1) begin
                    state_next = B_MULX;
                end
            end
            B_MULX: begin
                prod_next  = 51'(cos_w * $signed({1'b0, rad}));
                state_next = B_MULY;
            end
            B_MULY: begin
                px_next    = place(prod_reg, job_reg.data.center_x);
                prod_next  = 51'(sin_w * $signed({1'b0, rad}));
                state_next = B_EMIT;
            end
            B_EMIT: begin
                if (free) begin
                    out_next              = '0;
                    out_next.pos_x        = px_reg;
                    out_next.pos_y        = place(prod_reg, job_reg.data.center_y);
                    out_next.vertex_depth = job_reg.data.depth;
                    out_next.vertex_color = job_reg.data.color_rgba;
                    out_next.has_triangle = step_reg != 5'd0;
                    if (!ring) begin
                        out_next.vertex_index = ii + 6'd1;
                        if (step_reg != 5'd0) begin
                            out_next.tri_a = ii + 6'd1;
                            out_next.tri_b = ii;
                        end
                    end else if (!side_reg) begin
                        out_next.vertex_index = {ii[4:0], 1'b0};
                        if (step_reg != 5'd0) begin
                            out_next.tri_a = {ii[4:0], 1'b0} - 6'd1;
                            out_next.tri_b = {ii[4:0], 1'b0} - 6'd2;
                            out_next.tri_c = {ii[4:0], 1'b0};
                        end
                    end else begin
                        out_next.vertex_index = {ii[4:0], 1'b1};
                        if (step_reg != 5'd0) begin
                            out_next.tri_a = {ii[4:0], 1'b0} - 6'd1;
                            out_next.tri_b = {ii[4:0], 1'b0};
                            out_next.tri_c = {ii[4:0], 1'b1};
                        end
                    end
                    out_next.last  = (step_reg == job_reg.segs) && (!ring || side_reg);
                    out_valid_next = 1'b1;
                    if (ring && !side_reg) begin
                        side_next  = 1'b1;
                        state_next = B_MULX;
                    end else if (step_reg == job_reg.segs) begin
                        state_next = B_IDLE;
                    end else begin
                        side_next  = 1'b0;
                        step_next  = step_reg + 5'd1;
                        r_next     = carry ? 5'(rsum - {1'b0, job_reg.segs}) : rsum[4:0];
                        q_next     = q_reg + job_reg.quot + {31'd0, carry};
                        state_next = B_START;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        job_reg  <= job_next;
        step_reg <= step_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        side_reg <= side_next;
        it_reg   <= it_next;
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        prod_reg <= prod_next;
        px_reg   <= px_next;
        out_reg  <= out_next;
    end

    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CORDIC |-> 32'(it_reg) < CORDIC_ITERATIONS)
        else $error("cordic iteration count overran");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != B_IDLE |-> step_reg <= job_reg.segs)
        else $error("step counter beyond segment count");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != B_IDLE |-> r_reg < job_reg.segs)
        else $error("phase remainder not reduced");

    a_tri_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.has_triangle |-> out_reg.vertex_index != 6'd0)
        else $error("triangle on first vertex");

endmodule

// ----- hdl/arc_sector_tessellator_core.sv -----
// Top level of the arc sector tessellator: config register, front end, queue, back end.
// The front end divides the span by the step count; then, for each step, the back end runs
// the CORDIC for the angle and scales and outputs each vertex (two per ring step).
// Commands pass through the single shared CORDIC and multiplier one at a time, while the
// front end and the queue can take further commands.
// Reset: rst_n clears all control state and queue; segment_count returns to 20.
module arc_sector_tessellator_core #(
    parameter int unsigned MAX_SEGMENTS      = 31,
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_wdata,
    input  logic          in_valid,
    output logic          in_ready,
    input  ast_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ast_pkg::out_t out_data
);
    import ast_pkg::*;

    logic [4:0] seg_reg;
    logic       fj_valid, fj_ready, bj_valid, bj_ready;
    job_t       fj_data, bj_data;

    // Hold the segment count register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seg_reg <= SEG_RESET;
        end else if (cfg_we) begin
            seg_reg <= cfg_wdata;
        end
    end

    ast_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_cfg   (seg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job_data  (fj_data)
    );

    ast_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_data  (fj_data),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_data   (bj_data)
    );

    ast_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job_data  (bj_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
